[hw/rtl/assert_macros.svh]
// assertion helpers used by the decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/htd_pkg.sv]
package htd_pkg;

    // node table geometry
    localparam int NODE_COUNT = 512;
    localparam int IDX_BITS   = $clog2(NODE_COUNT);
    localparam int SYM_BITS   = 8;
    localparam int SYM_FIELD  = 8;

    // configuration port
    localparam int ADDR_BITS = 3;
    localparam logic REG_ROOT_NODE = 1'b0;

    // item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // decode sequencer phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CUR   = 2'd1;
    localparam logic [1:0] PH_CHILD = 2'd2;

    // one node table entry
    typedef struct packed {
        logic [IDX_BITS-1:0] left_idx;
        logic [IDX_BITS-1:0] right_idx;
        logic                leaf;
        logic [SYM_BITS-1:0] sym;
    } node_t;

endpackage

[hw/rtl/htd_if.sv]
// input item channel
interface htd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [htd_pkg::IDX_BITS-1:0]  node_index;
    logic [htd_pkg::IDX_BITS-1:0]  left_child;
    logic [htd_pkg::IDX_BITS-1:0]  right_child;
    logic                          is_leaf;
    logic [htd_pkg::SYM_FIELD-1:0] leaf_symbol;
    logic                          code_bit;
    logic                          end_of_stream;

    modport source (
        output valid, mode, node_index, left_child, right_child, is_leaf,
               leaf_symbol, code_bit, end_of_stream,
        input  ready
    );
    modport sink (
        input  valid, mode, node_index, left_child, right_child, is_leaf,
               leaf_symbol, code_bit, end_of_stream,
        output ready
    );
endinterface

// result item channel
interface htd_out_if;
    logic                          valid;
    logic                          ready;
    logic [htd_pkg::SYM_FIELD-1:0] symbol;
    logic                          incomplete;

    modport source (
        output valid, symbol, incomplete,
        input  ready
    );
    modport sink (
        input  valid, symbol, incomplete,
        output ready
    );
endinterface

[hw/rtl/huffman_tree_decoder_core.sv]
// a decode bit's result enters the output register at the end of its child phase
// throughput: one load item per cycle while idle; during a decode, intake waits for it to finish
// a decode makes two dependent reads of the node memory: current node, then its child
// a waiting result holds the next decode in its child phase, and intake with it, until it leaves
// reset clears the phase, the walk, the output valid flag and root_node; the node memory is not
// cleared and holds undefined data until loaded
`include "assert_macros.svh"

module huffman_tree_decoder_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [htd_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    htd_in_if.sink                         in_ch,
    htd_out_if.source                      out_ch
);

    // node memory
    htd_pkg::node_t node_mem [htd_pkg::NODE_COUNT];
    htd_pkg::node_t rd_data_reg;
    logic                           rd_en;
    logic [htd_pkg::IDX_BITS-1:0]   rd_addr;

    // control state
    logic [1:0]                     phase_reg, phase_next;
    logic                           walk_active_reg, walk_active_next;
    logic [htd_pkg::IDX_BITS-1:0]   walk_node_reg, walk_node_next;
    logic [htd_pkg::IDX_BITS-1:0]   root_reg;

    // per-item working registers
    logic                           bit_reg;
    logic                           eos_reg;
    logic                           cur_leaf_reg;
    logic [htd_pkg::SYM_BITS-1:0]   cur_sym_reg;
    logic [htd_pkg::IDX_BITS-1:0]   child_idx_reg;

    // output register
    logic                           out_valid_reg, out_valid_next;
    logic [htd_pkg::SYM_FIELD-1:0]  out_symbol_reg, out_symbol_next;
    logic                           out_incomplete_reg, out_incomplete_next;

    logic                           in_fire;
    logic                           decode_fire;
    logic                           load_fire;
    logic                           out_free;
    logic                           finish;
    logic [htd_pkg::IDX_BITS-1:0]   child_sel;
    logic                           cfg_write;

    // handshake
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign finish      = (phase_reg == htd_pkg::PH_CHILD) && out_free;
    assign in_ch.ready = (phase_reg == htd_pkg::PH_IDLE) || finish;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign decode_fire = in_fire && (in_ch.mode == htd_pkg::MODE_DECODE);
    assign load_fire   = in_fire && (in_ch.mode == htd_pkg::MODE_LOAD);

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.symbol     = out_symbol_reg;
    assign out_ch.incomplete = out_incomplete_reg;

    // child taken from the current node's entry
    assign child_sel = bit_reg ? rd_data_reg.right_idx : rd_data_reg.left_idx;

    // walk update and result at the end of a decode
    always_comb
    begin
        walk_active_next    = walk_active_reg;
        walk_node_next      = walk_node_reg;
        out_valid_next      = out_valid_reg && !out_ch.ready;
        out_symbol_next     = out_symbol_reg;
        out_incomplete_next = out_incomplete_reg;
        if (finish)
        begin
            if (cur_leaf_reg || rd_data_reg.leaf)
            begin
                out_valid_next      = 1'b1;
                out_symbol_next     = cur_leaf_reg
                                      ? htd_pkg::SYM_FIELD'(cur_sym_reg)
                                      : htd_pkg::SYM_FIELD'(rd_data_reg.sym);
                out_incomplete_next = 1'b0;
                walk_active_next    = 1'b0;
                walk_node_next      = '0;
            end
            else if (eos_reg)
            begin
                out_valid_next      = 1'b1;
                out_symbol_next     = '0;
                out_incomplete_next = 1'b1;
                walk_active_next    = 1'b0;
                walk_node_next      = '0;
            end
            else
            begin
                walk_active_next = 1'b1;
                walk_node_next   = child_idx_reg;
            end
        end
    end

    // phase sequencing
    always_comb
    begin
        case (phase_reg)
            htd_pkg::PH_IDLE:
            begin
                phase_next = decode_fire ? htd_pkg::PH_CUR : htd_pkg::PH_IDLE;
            end
            htd_pkg::PH_CUR:
            begin
                phase_next = htd_pkg::PH_CHILD;
            end
            htd_pkg::PH_CHILD:
            begin
                if (!finish)
                    phase_next = htd_pkg::PH_CHILD;
                else if (decode_fire)
                    phase_next = htd_pkg::PH_CUR;
                else
                    phase_next = htd_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = htd_pkg::PH_IDLE;
            end
        endcase
    end

    // read port: current node on transfer, child node in the following cycle
    assign rd_en   = decode_fire || (phase_reg == htd_pkg::PH_CUR);
    assign rd_addr = (phase_reg == htd_pkg::PH_CUR) ? child_sel
                   : (walk_active_next ? walk_node_next : root_reg);

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            node_mem[in_ch.node_index] <= '{
                left_idx:  in_ch.left_child,
                right_idx: in_ch.right_child,
                leaf:      in_ch.is_leaf,
                sym:       in_ch.leaf_symbol[htd_pkg::SYM_BITS-1:0]
            };
        end
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (decode_fire)
        begin
            bit_reg <= in_ch.code_bit;
            eos_reg <= in_ch.end_of_stream;
        end
        if (phase_reg == htd_pkg::PH_CUR)
        begin
            cur_leaf_reg  <= rd_data_reg.leaf;
            cur_sym_reg   <= rd_data_reg.sym;
            child_idx_reg <= child_sel;
        end
        out_symbol_reg     <= out_symbol_next;
        out_incomplete_reg <= out_incomplete_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= htd_pkg::PH_IDLE;
            walk_active_reg <= 1'b0;
            walk_node_reg   <= '0;
            out_valid_reg   <= 1'b0;
            root_reg        <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            walk_active_reg <= walk_active_next;
            walk_node_reg   <= walk_node_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_write)
                root_reg <= pwdata[htd_pkg::IDX_BITS-1:0];
        end
    end

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[htd_pkg::ADDR_BITS-1] == htd_pkg::REG_ROOT_NODE);
    assign prdata    = (paddr[htd_pkg::ADDR_BITS-1] == htd_pkg::REG_ROOT_NODE)
                       ? 32'(root_reg) : 32'd0;

    // checks
    `ASSERT_NXT(a_cur_to_child, clk, rst_n, phase_reg == htd_pkg::PH_CUR,
        phase_reg == htd_pkg::PH_CHILD, "child read did not follow current node read")
    `ASSERT_IMP(a_no_intake_mid_read, clk, rst_n, phase_reg == htd_pkg::PH_CUR,
        !in_ch.ready, "transfer taken between the two node reads")
    `ASSERT_NXT(a_hold_when_blocked, clk, rst_n,
        (phase_reg == htd_pkg::PH_CHILD) && out_valid_reg && !out_ch.ready,
        (phase_reg == htd_pkg::PH_CHILD) && $stable(walk_node_reg),
        "decode finished while the output register was occupied")
    `ASSERT_IMP(a_incomplete_zero, clk, rst_n, out_valid_reg && out_incomplete_reg,
        out_symbol_reg == '0, "incomplete result carries a symbol")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    typedef logic [htd_pkg::IDX_BITS-1:0]  node_idx_t;
    typedef logic [htd_pkg::SYM_FIELD-1:0] sym_t;

    // one item on the code channel
    typedef struct {
        logic      mode;
        node_idx_t node_index;
        node_idx_t left_child;
        node_idx_t right_child;
        logic      is_leaf;
        sym_t      leaf_symbol;
        logic      code_bit;
        logic      end_of_stream;
    } code_item_t;

    // one decoded result
    typedef struct {
        sym_t symbol;
        logic incomplete;
    } sym_result_t;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned PHASE_ITEMS     = 135;
    localparam int unsigned NOISE_PCT       = 10;
    localparam int unsigned EOS_PCT         = 8;
    localparam node_idx_t   LAST_NODE       = node_idx_t'(htd_pkg::NODE_COUNT - 1);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [htd_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    htd_in_if  code_in ();
    htd_out_if sym_out ();

    huffman_tree_decoder_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (code_in),
        .out_ch  (sym_out)
    );

    always #4 clk = ~clk;

    // shadow copy of the node table and the walk
    node_idx_t   left_of   [htd_pkg::NODE_COUNT];
    node_idx_t   right_of  [htd_pkg::NODE_COUNT];
    logic        leaf_of   [htd_pkg::NODE_COUNT];
    sym_t        symbol_of [htd_pkg::NODE_COUNT];
    bit          node_loaded [htd_pkg::NODE_COUNT];
    node_idx_t   loaded_nodes [$];
    node_idx_t   walk_at;
    logic        walk_busy;
    node_idx_t   root_cfg;

    sym_result_t symbols_due [$];

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned loads_sent;
    int unsigned bits_sent;
    int unsigned root_writes;
    int unsigned symbols_checked;
    int unsigned incompletes_checked;
    int unsigned quiet_cycles;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // advance the shadow table and walk by one accepted item
    function automatic void tree_step(input code_item_t it);
        node_idx_t   cur;
        node_idx_t   nxt;
        sym_result_t r;
        if (it.mode == htd_pkg::MODE_LOAD)
        begin
            left_of[it.node_index]   = it.left_child;
            right_of[it.node_index]  = it.right_child;
            leaf_of[it.node_index]   = it.is_leaf;
            symbol_of[it.node_index] = it.leaf_symbol;
            if (!node_loaded[it.node_index])
            begin
                node_loaded[it.node_index] = 1'b1;
                loaded_nodes.insert(loaded_nodes.size(), it.node_index);
            end
            return;
        end
        cur = walk_busy ? walk_at : root_cfg;
        // walk starting on a leaf emits without moving
        if (leaf_of[cur])
        begin
            r.symbol     = symbol_of[cur];
            r.incomplete = 1'b0;
            symbols_due.insert(symbols_due.size(), r);
            walk_busy = 1'b0;
            walk_at   = '0;
            return;
        end
        nxt = it.code_bit ? right_of[cur] : left_of[cur];
        if (leaf_of[nxt])
        begin
            r.symbol     = symbol_of[nxt];
            r.incomplete = 1'b0;
            symbols_due.insert(symbols_due.size(), r);
            walk_busy = 1'b0;
            walk_at   = '0;
            return;
        end
        // stream ends inside a code
        if (it.end_of_stream)
        begin
            r.symbol     = '0;
            r.incomplete = 1'b1;
            symbols_due.insert(symbols_due.size(), r);
            walk_busy = 1'b0;
            walk_at   = '0;
            return;
        end
        walk_at   = nxt;
        walk_busy = 1'b1;
    endfunction

    function automatic code_item_t node_load(input node_idx_t idx, input node_idx_t lc,
                                             input node_idx_t rc, input logic leaf,
                                             input sym_t s);
        code_item_t it;
        it.mode          = htd_pkg::MODE_LOAD;
        it.node_index    = idx;
        it.left_child    = lc;
        it.right_child   = rc;
        it.is_leaf       = leaf;
        it.leaf_symbol   = s;
        it.code_bit      = 1'($urandom_range(0, 1));
        it.end_of_stream = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic code_item_t code_bit_item(input logic b, input logic eos);
        code_item_t it;
        it.mode          = htd_pkg::MODE_DECODE;
        it.node_index    = node_idx_t'($urandom_range(0, htd_pkg::NODE_COUNT - 1));
        it.left_child    = node_idx_t'($urandom_range(0, htd_pkg::NODE_COUNT - 1));
        it.right_child   = node_idx_t'($urandom_range(0, htd_pkg::NODE_COUNT - 1));
        it.is_leaf       = 1'($urandom_range(0, 1));
        it.leaf_symbol   = sym_t'($urandom);
        it.code_bit      = b;
        it.end_of_stream = eos;
        return it;
    endfunction

    // drive one item and wait for its transfer
    task automatic send_item(input code_item_t it);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            code_in.valid <= 1'b0;
            @(posedge clk);
        end
        code_in.valid         <= 1'b1;
        code_in.mode          <= it.mode;
        code_in.node_index    <= it.node_index;
        code_in.left_child    <= it.left_child;
        code_in.right_child   <= it.right_child;
        code_in.is_leaf       <= it.is_leaf;
        code_in.leaf_symbol   <= it.leaf_symbol;
        code_in.code_bit      <= it.code_bit;
        code_in.end_of_stream <= it.end_of_stream;
        @(posedge clk);
        while (!code_in.ready) @(posedge clk);
        tree_step(it);
        items_sent++;
        if (it.mode == htd_pkg::MODE_LOAD)
            loads_sent++;
        else
            bits_sent++;
    endtask

    // stop sending and let the block run dry
    task automatic settle_idle();
        code_in.valid <= 1'b0;
        while (symbols_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write root_node, then read it back
    task automatic write_root(input node_idx_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {htd_pkg::REG_ROOT_NODE, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        root_cfg = value;
        root_writes++;
        // back-to-back read access
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== 32'(root_cfg))
            report_mismatch($sformatf("root_node read %0h, expected %0h", prdata, root_cfg));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // build a random well-formed tree at the current root, loaded in random order
    task automatic load_random_tree(input int unsigned leaves);
        node_idx_t   at [32];
        int unsigned lslot [32];
        int unsigned rslot [32];
        bit          internal [32];
        bit          taken [htd_pkg::NODE_COUNT];
        int unsigned open_leaves [$];
        int unsigned order [$];
        int unsigned n;
        int unsigned s;
        int unsigned p;
        node_idx_t   pick;
        foreach (taken[i]) taken[i] = 1'b0;
        foreach (internal[i]) internal[i] = 1'b0;
        at[0] = root_cfg;
        taken[root_cfg] = 1'b1;
        n = 1;
        open_leaves.insert(open_leaves.size(), 0);
        // split a random leaf until the tree has enough leaves
        for (int unsigned k = 1; k < leaves; k++)
        begin
            p = $urandom_range(0, open_leaves.size() - 1);
            s = open_leaves[p];
            open_leaves.delete(p);
            internal[s] = 1'b1;
            lslot[s] = n;
            rslot[s] = n + 1;
            repeat (2)
            begin
                pick = node_idx_t'($urandom_range(0, htd_pkg::NODE_COUNT - 1));
                while (taken[pick])
                    pick = node_idx_t'($urandom_range(0, htd_pkg::NODE_COUNT - 1));
                taken[pick] = 1'b1;
                at[n] = pick;
                open_leaves.insert(open_leaves.size(), n);
                n++;
            end
        end
        for (int unsigned k = 0; k < n; k++) order.insert(order.size(), k);
        while (order.size() != 0)
        begin
            p = $urandom_range(0, order.size() - 1);
            s = order[p];
            order.delete(p);
            // leaf children point back into the tree so every entry stays loaded
            if (internal[s])
                send_item(node_load(at[s], at[lslot[s]], at[rslot[s]], 1'b0, sym_t'($urandom)));
            else
                send_item(node_load(at[s], at[$urandom_range(0, n - 1)],
                                    at[$urandom_range(0, n - 1)], 1'b1, sym_t'($urandom)));
        end
    endtask

    // trees followed by code bit streams, with stray loads and early stream ends
    task automatic run_random_streams(input int unsigned n_items);
        int unsigned start;
        int unsigned leaves;
        node_idx_t   lc;
        node_idx_t   rc;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(0, 7) == 0)
                leaves = 1;
            else
                leaves = $urandom_range(2, ($urandom_range(0, 4) == 0) ? 16 : 6);
            load_random_tree(leaves);
            repeat ($urandom_range(6, 32))
            begin
                if ($urandom_range(0, 99) < NOISE_PCT)
                begin
                    lc = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
                    rc = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
                    send_item(node_load(
                        node_idx_t'($urandom_range(0, htd_pkg::NODE_COUNT - 1)), lc, rc,
                        1'($urandom_range(0, 1)), sym_t'($urandom)));
                end
                else
                begin
                    send_item(code_bit_item(1'($urandom_range(0, 1)),
                                            $urandom_range(0, 99) < EOS_PCT));
                end
            end
        end
    endtask

    task automatic test_directed_cases();
        write_root(9'd0);
        // root 0: bit 0 to leaf 511, bit 1 to node 2 with leaves 3 and 4
        send_item(node_load(9'd0, LAST_NODE, 9'd2, 1'b0, 8'hFF));
        send_item(node_load(LAST_NODE, 9'd0, 9'd0, 1'b1, 8'hFF));
        send_item(node_load(9'd2, 9'd3, 9'd4, 1'b0, 8'h00));
        send_item(node_load(9'd3, LAST_NODE, LAST_NODE, 1'b1, 8'h00));
        send_item(node_load(9'd4, 9'd0, 9'd0, 1'b1, 8'h5A));
        // one-bit code, then a two-bit code
        send_item(code_bit_item(1'b0, 1'b0));
        send_item(code_bit_item(1'b1, 1'b0));
        send_item(code_bit_item(1'b0, 1'b0));
        // leaf reached on the last bit of the stream
        send_item(code_bit_item(1'b1, 1'b0));
        send_item(code_bit_item(1'b1, 1'b1));
        // stream ends inside a code
        send_item(code_bit_item(1'b1, 1'b1));
        // root moves to a single leaf while a walk is inside a code
        send_item(code_bit_item(1'b1, 1'b0));
        settle_idle();
        write_root(LAST_NODE);
        send_item(code_bit_item(1'b0, 1'b0));
        send_item(code_bit_item(1'b1, 1'b0));
        send_item(code_bit_item(1'b0, 1'b1));
        // node load in the middle of a walk
        settle_idle();
        write_root(9'd0);
        send_item(code_bit_item(1'b1, 1'b0));
        send_item(node_load(9'd4, LAST_NODE, LAST_NODE, 1'b1, 8'hA5));
        send_item(code_bit_item(1'b1, 1'b0));
    endtask

    task automatic test_streaming_no_idle();
        settle_idle();
        write_root(node_idx_t'($urandom_range(1, htd_pkg::NODE_COUNT - 2)));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random_streams(PHASE_ITEMS);
    endtask

    task automatic test_sender_gaps();
        settle_idle();
        write_root(LAST_NODE);
        src_idle_pct   = 61;
        sink_stall_pct = 0;
        run_random_streams(PHASE_ITEMS);
    endtask

    task automatic test_receiver_stalls();
        settle_idle();
        write_root(node_idx_t'($urandom_range(0, htd_pkg::NODE_COUNT - 1)));
        src_idle_pct   = 0;
        sink_stall_pct = 61;
        run_random_streams(PHASE_ITEMS);
    endtask

    task automatic test_both_sides_idle();
        settle_idle();
        write_root(9'd0);
        src_idle_pct   = 26;
        sink_stall_pct = 26;
        run_random_streams(PHASE_ITEMS);
    endtask

    // result sink: random stalls and comparison against the oldest due symbol
    always @(posedge clk)
    begin : result_check
        sym_result_t due;
        sym_out.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (rst_n && sym_out.valid && sym_out.ready)
        begin
            if (symbols_due.size() == 0)
            begin
                report_mismatch($sformatf("result %0h/%0b with nothing due",
                                          sym_out.symbol, sym_out.incomplete));
            end
            else
            begin
                due = symbols_due.pop_front();
                if (sym_out.symbol !== due.symbol)
                    report_mismatch($sformatf("symbol %0h, expected %0h",
                                              sym_out.symbol, due.symbol));
                if (sym_out.incomplete !== due.incomplete)
                    report_mismatch($sformatf("incomplete %0b, expected %0b",
                                              sym_out.incomplete, due.incomplete));
                if (due.incomplete)
                    incompletes_checked++;
                else
                    symbols_checked++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles = 0;
        end
        else if ((code_in.valid && code_in.ready) || (sym_out.valid && sym_out.ready)
                 || (psel && penable))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results still due",
                         quiet_cycles, symbols_due.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        code_in.valid         = 1'b0;
        code_in.mode          = htd_pkg::MODE_LOAD;
        code_in.node_index    = '0;
        code_in.left_child    = '0;
        code_in.right_child   = '0;
        code_in.is_leaf       = 1'b0;
        code_in.leaf_symbol   = '0;
        code_in.code_bit      = 1'b0;
        code_in.end_of_stream = 1'b0;
        sym_out.ready         = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        walk_at               = '0;
        walk_busy             = 1'b0;
        root_cfg              = '0;
        src_idle_pct          = 0;
        sink_stall_pct        = 0;
        foreach (node_loaded[i]) node_loaded[i] = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_streaming_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_sides_idle();
        settle_idle();

        $display("covered %0d items (%0d node loads, %0d code bits) over %0d root settings",
                 items_sent, loads_sent, bits_sent, root_writes);
        $display("checked %0d decoded symbols and %0d incomplete codes, %0d mismatches",
                 symbols_checked, incompletes_checked, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/htd_pkg.sv
hw/rtl/htd_if.sv
hw/rtl/huffman_tree_decoder_core.sv
tb/tb_top.sv
